// ===== hdl/rmf_pkg.sv =====
package rmf_pkg;

   localparam int CHANNEL_W = 2;
   localparam int SAMPLE_W  = 16;
   localparam int TAG_W     = 16;

   typedef logic [CHANNEL_W-1:0] channel_type;
   typedef logic [SAMPLE_W-1:0]  value_type;
   typedef logic [TAG_W-1:0]     tag_type;

   // every window starts out filled with this value
   localparam value_type INIT_VALUE = value_type'(10);

   // one slot of a sorted window
   typedef struct packed {
      value_type value;
      tag_type   tag;
   } entry_type;

   // classified request handed from the front to the engine
   typedef struct packed {
      channel_type channel;
      value_type   sample;
      logic        in_range;
   } cmd_type;

endpackage

// ===== hdl/rmf_fifo.sv =====
module rmf_fifo #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 2
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] wdata,
   output logic             full,
   input  logic             pop,
   output logic [WIDTH-1:0] rdata,
   output logic             empty
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] slot_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push;
   logic             do_pop;

   assign full    = (count_ff == CNT_W'(DEPTH));
   assign empty   = (count_ff == '0);
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;
   assign rdata   = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= wdata;
      end
   end

endmodule

// ===== hdl/rmf_front.sv =====
module rmf_front #(
   parameter int CHANNELS = 4
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_push,
   input  rmf_pkg::channel_type req_channel,
   input  rmf_pkg::value_type   req_sample,
   output logic                 req_full,
   output logic                 cmd_valid,
   output rmf_pkg::cmd_type     cmd,
   input  logic                 cmd_pop
);

   localparam int CMD_W = $bits(rmf_pkg::cmd_type);

   rmf_pkg::cmd_type   cmd_in;
   logic [CMD_W-1:0]   cmd_bits;
   logic               cmd_empty;

   // channels beyond the configured count are flagged here and skip the engine walk
   always_comb begin
      cmd_in.channel  = req_channel;
      cmd_in.sample   = req_sample;
      cmd_in.in_range = (int'(req_channel) < CHANNELS);
   end

   rmf_fifo #(
      .WIDTH (CMD_W),
      .DEPTH (2)
   ) u_cmd_fifo (
      .clock (clock),
      .reset (reset),
      .push  (req_push),
      .wdata (cmd_in),
      .full  (req_full),
      .pop   (cmd_pop),
      .rdata (cmd_bits),
      .empty (cmd_empty)
   );

   assign cmd       = rmf_pkg::cmd_type'(cmd_bits);
   assign cmd_valid = !cmd_empty;

endmodule

// ===== hdl/rmf_engine.sv =====
module rmf_engine #(
   parameter int WINDOW_SIZE = 7,
   parameter int CHANNELS    = 4
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               cmd_valid,
   input  rmf_pkg::cmd_type   cmd,
   output logic               cmd_pop,
   input  logic               out_full,
   output logic               out_push,
   output rmf_pkg::value_type out_median
);

   localparam int IDX_W  = $clog2(WINDOW_SIZE + 1);
   localparam int POS_W  = $clog2(WINDOW_SIZE);
   localparam int CH_IW  = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
   localparam int DEPTH  = 2 * CHANNELS * WINDOW_SIZE;
   localparam int ADDR_W = $clog2(DEPTH);
   localparam int MID    = WINDOW_SIZE / 2;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_WALK,
      ST_POST
   } state_type;

   function automatic logic [ADDR_W-1:0] slot_addr(input logic bank,
                                                   input logic [CH_IW-1:0] ch,
                                                   input logic [POS_W-1:0] pos);
      slot_addr = ADDR_W'(((int'(bank) * CHANNELS) + int'(ch)) * WINDOW_SIZE + int'(pos));
   endfunction

   // two banks per channel: walk reads the current one and writes the other
   rmf_pkg::entry_type win_mem_ff [DEPTH];
   rmf_pkg::entry_type rdata_ff;

   rmf_pkg::tag_type   oldest_ff [CHANNELS];
   logic [CHANNELS-1:0] bank_ff;
   logic [CHANNELS-1:0] row_valid_ff;

   state_type          state_ff, state_in;
   logic [CH_IW-1:0]   ch_ff, ch_in;
   rmf_pkg::value_type sample_ff, sample_in;
   rmf_pkg::tag_type   old_tag_ff, old_tag_in;
   logic               row_ok_ff, row_ok_in;
   logic               bank_cur_ff, bank_cur_in;
   logic [IDX_W-1:0]   idx_ff, idx_in;
   logic [POS_W-1:0]   j_ff, j_in;
   logic               skipped_ff, skipped_in;
   logic               inserted_ff, inserted_in;
   rmf_pkg::value_type median_ff, median_in;

   logic [CH_IW-1:0]   start_ch;
   logic [ADDR_W-1:0]  rd_addr;
   logic [ADDR_W-1:0]  wr_addr;
   logic               wr_en;
   rmf_pkg::entry_type wr_data;
   rmf_pkg::entry_type cur;
   rmf_pkg::entry_type fresh;
   logic               have_cur;
   logic               consume;
   logic [IDX_W-1:0]   idx_next;
   logic [POS_W-1:0]   rd_pos;
   logic               finish;

   assign start_ch = CH_IW'(cmd.channel);
   assign have_cur = (idx_ff < IDX_W'(WINDOW_SIZE));
   assign fresh    = '{value: sample_ff, tag: old_tag_ff + rmf_pkg::tag_type'(WINDOW_SIZE)};
   assign wr_addr  = slot_addr(~bank_cur_ff, ch_ff, j_ff);

   // a channel never written since reset reads as its initial window
   always_comb begin
      if (row_ok_ff) begin
         cur = rdata_ff;
      end else begin
         cur = '{value: rmf_pkg::INIT_VALUE, tag: rmf_pkg::tag_type'(idx_ff)};
      end
   end

   always_comb begin
      state_in    = state_ff;
      ch_in       = ch_ff;
      sample_in   = sample_ff;
      old_tag_in  = old_tag_ff;
      row_ok_in   = row_ok_ff;
      bank_cur_in = bank_cur_ff;
      idx_in      = idx_ff;
      j_in        = j_ff;
      skipped_in  = skipped_ff;
      inserted_in = inserted_ff;
      median_in   = median_ff;
      cmd_pop     = 1'b0;
      out_push    = 1'b0;
      out_median  = median_ff;
      wr_en       = 1'b0;
      wr_data     = cur;
      consume     = 1'b0;
      finish      = 1'b0;
      idx_next    = idx_ff + IDX_W'(1);
      rd_pos      = (idx_next >= IDX_W'(WINDOW_SIZE)) ? POS_W'(WINDOW_SIZE - 1)
                                                     : POS_W'(idx_next);
      rd_addr     = slot_addr(bank_cur_ff, ch_ff, POS_W'(idx_ff));

      unique case (state_ff)
         ST_IDLE: begin
            rd_addr = slot_addr(bank_ff[start_ch], start_ch, '0);
            if (cmd_valid && !out_full) begin
               cmd_pop = 1'b1;
               if (!cmd.in_range) begin
                  out_push   = 1'b1;
                  out_median = '0;
               end else begin
                  ch_in       = start_ch;
                  sample_in   = cmd.sample;
                  old_tag_in  = oldest_ff[start_ch];
                  row_ok_in   = row_valid_ff[start_ch];
                  bank_cur_in = bank_ff[start_ch];
                  idx_in      = '0;
                  j_in        = '0;
                  skipped_in  = 1'b0;
                  inserted_in = 1'b0;
                  state_in    = ST_WALK;
               end
            end
         end
         ST_WALK: begin
            // merge: drop the oldest entry, slip the sample in before the first larger one
            if (have_cur && !skipped_ff &&
                (cur.tag == old_tag_ff || idx_ff == IDX_W'(WINDOW_SIZE - 1))) begin
               consume    = 1'b1;
               skipped_in = 1'b1;
            end else if (have_cur && (inserted_ff || cur.value <= sample_ff)) begin
               consume = 1'b1;
               wr_en   = 1'b1;
               wr_data = cur;
            end else begin
               wr_en       = 1'b1;
               wr_data     = fresh;
               inserted_in = 1'b1;
            end
            if (consume) begin
               idx_in  = idx_next;
               rd_addr = slot_addr(bank_cur_ff, ch_ff, rd_pos);
            end
            if (wr_en) begin
               if (j_ff == POS_W'(MID)) begin
                  median_in = wr_data.value;
               end
               if (j_ff == POS_W'(WINDOW_SIZE - 1)) begin
                  finish   = 1'b1;
                  state_in = ST_POST;
               end else begin
                  j_in = j_ff + POS_W'(1);
               end
            end
         end
         ST_POST: begin
            out_push = 1'b1;
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         bank_ff      <= '0;
         row_valid_ff <= '0;
         for (int c = 0; c < CHANNELS; c++) begin
            oldest_ff[c] <= '0;
         end
      end else begin
         state_ff <= state_in;
         if (finish) begin
            oldest_ff[ch_ff]    <= old_tag_ff + rmf_pkg::tag_type'(1);
            bank_ff[ch_ff]      <= ~bank_cur_ff;
            row_valid_ff[ch_ff] <= 1'b1;
         end
      end
      ch_ff       <= ch_in;
      sample_ff   <= sample_in;
      old_tag_ff  <= old_tag_in;
      row_ok_ff   <= row_ok_in;
      bank_cur_ff <= bank_cur_in;
      idx_ff      <= idx_in;
      j_ff        <= j_in;
      skipped_ff  <= skipped_in;
      inserted_ff <= inserted_in;
      median_ff   <= median_in;
      if (wr_en) begin
         win_mem_ff[wr_addr] <= wr_data;
      end
      rdata_ff <= win_mem_ff[rd_addr];
   end

endmodule

// ===== hdl/running_median_filter.sv =====
// Multi-channel running median over a sliding window of WINDOW_SIZE samples per channel.
// Push a channel number and an unsigned 16-bit sample; one median word comes back per
// request, in request order. In the engine a request passes a start step, then a walk
// over the channel's sorted window that writes one entry per cycle, apart from one step
// that drops the oldest entry unless that entry sits in the last slot behind the new
// sample, and then a post step. A channel number at or above CHANNELS returns 0 and
// changes nothing. The window store holds 2*CHANNELS*WINDOW_SIZE entries in two banks
// per channel; a channel not yet used reads as a window of tens, so no clearing pass
// runs after reset. Two-entry queues sit on the request side and on the result side.
module running_median_filter #(
   parameter int WINDOW_SIZE = 7,
   parameter int CHANNELS    = 4
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_push,
   input  rmf_pkg::channel_type req_channel,
   input  rmf_pkg::value_type   req_sample,
   output logic                 req_full,
   input  logic                 rsp_pop,
   output rmf_pkg::value_type   rsp_median,
   output logic                 rsp_empty
);

   localparam int VALUE_W = $bits(rmf_pkg::value_type);

   logic               cmd_valid;
   rmf_pkg::cmd_type   cmd;
   logic               cmd_pop;
   logic               out_full;
   logic               out_push;
   rmf_pkg::value_type out_median;
   logic [VALUE_W-1:0] rsp_bits;

   rmf_front #(
      .CHANNELS (CHANNELS)
   ) u_front (
      .clock       (clock),
      .reset       (reset),
      .req_push    (req_push),
      .req_channel (req_channel),
      .req_sample  (req_sample),
      .req_full    (req_full),
      .cmd_valid   (cmd_valid),
      .cmd         (cmd),
      .cmd_pop     (cmd_pop)
   );

   rmf_engine #(
      .WINDOW_SIZE (WINDOW_SIZE),
      .CHANNELS    (CHANNELS)
   ) u_engine (
      .clock      (clock),
      .reset      (reset),
      .cmd_valid  (cmd_valid),
      .cmd        (cmd),
      .cmd_pop    (cmd_pop),
      .out_full   (out_full),
      .out_push   (out_push),
      .out_median (out_median)
   );

   rmf_fifo #(
      .WIDTH (VALUE_W),
      .DEPTH (2)
   ) u_rsp_fifo (
      .clock (clock),
      .reset (reset),
      .push  (out_push),
      .wdata (out_median),
      .full  (out_full),
      .pop   (rsp_pop),
      .rdata (rsp_bits),
      .empty (rsp_empty)
   );

   assign rsp_median = rmf_pkg::value_type'(rsp_bits);

endmodule
